// ----- hw/rtl/sslew_pkg.sv -----
// ----------------------------------------------------------------------------
// sslew_pkg
// Shared types, codes and constants of the servo slew channel controller.
// ----------------------------------------------------------------------------
package sslew_pkg;

    localparam int SERVO_COUNT_DEF = 16;
    localparam logic [11:0] MAX_TICKS = 12'd4095;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_ENABLE  = 3'd1,
        OP_DISABLE = 3'd2,
        OP_DIS_ALL = 3'd3,
        OP_CAL     = 3'd4,
        OP_QUERY   = 3'd5,
        OP_TICK    = 3'd6,
        OP_NONE    = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    localparam logic [2:0] CFG_SMOOTH = 3'd0;
    localparam logic [2:0] CFG_STEP   = 3'd1;
    localparam logic [2:0] CFG_CENTER = 3'd2;
    localparam logic [2:0] CFG_MIN    = 3'd3;
    localparam logic [2:0] CFG_MAX    = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  servo_index;
        logic [15:0] pulse_width;
        logic [15:0] limit_low;
        logic [15:0] limit_high;
        logic [15:0] center_width;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel;
        logic [11:0] off_ticks;
        logic        full_on;
        logic        full_off;
        logic [15:0] current_width;
        logic [15:0] target_width;
        logic        is_enabled;
        logic        is_moving;
        logic        ok;
        logic        last;
    } result_t;

endpackage

// ----- hw/rtl/sslew_tick_conv.sv -----
// ----------------------------------------------------------------------------
// sslew_tick_conv
// Convert a pulse width to a channel write: ticks = p*128/625; full_on from 4095 up, full_off at 0.
// ----------------------------------------------------------------------------
module sslew_tick_conv
(
    input  logic [15:0] width,
    output logic [11:0] off_ticks,
    output logic        full_on,
    output logic        full_off
);
    // p*128/625 = (p*128*R) >> 40 with R = ceil(2^40/625); exact for p < 2^16
    localparam logic [30:0] RECIP = 31'd1759218605;
    logic [22:0] scaled;
    logic [53:0] prod;
    logic [13:0] t;

    always_comb
    begin
        scaled   = {width, 7'd0};
        prod     = 54'(scaled) * 54'(RECIP);
        t        = prod[53:40];
        full_off = (t == 14'd0);
        full_on  = (t >= 14'(sslew_pkg::MAX_TICKS));
        off_ticks = (full_off || full_on) ? 12'd0 : t[11:0];
    end
endmodule

// ----- hw/rtl/servo_slew_channel_controller_core.sv -----
// ----------------------------------------------------------------------------
// servo_slew_channel_controller_core
// Multi-servo slew-rate limiter with per-servo state held in one memory.
// ----------------------------------------------------------------------------
// Channel | Signals                         | Handshake
// cmd     | start, busy, cmd                | accepted when start && !busy
// result  | res_valid, res                  | one cycle strobe, no stall
// config  | cfg_valid, cfg_ready, cfg_index,| written when valid && ready
//         | cfg_data                        |
//
// A single-servo command holds busy through the read, modify and write, and
// report states; a rejected servo index goes straight to report. A tick or
// disable all walks every servo, a read and a modify and write state per
// entry as the state memory has a single port, then reports. Opcode 7 and a
// tick in direct mode are taken without going busy. After reset and after
// each write of a reset register a clearing pass, a read and a write state
// per servo, reloads the memory; busy is high during it. Config is taken
// only in idle with start low. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module servo_slew_channel_controller_core
#(
    parameter int SERVO_COUNT = sslew_pkg::SERVO_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sslew_pkg::cmd_t    cmd,
    output logic               res_valid,
    output sslew_pkg::result_t res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    typedef struct packed {
        logic [15:0] cur;
        logic [15:0] tgt;
        logic [15:0] mn;
        logic [15:0] mx;
        logic        en;
        logic        mv;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    entry_t mem [SERVO_COUNT];
    entry_t rd_reg;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    sslew_pkg::cmd_t cmd_reg;
    logic [3:0] clr_mask_reg, clr_mask_next;   // full, center, min, max reload

    logic        smooth_reg;
    logic [15:0] step_reg, center_reg, min_reg, max_reg;

    logic        we;
    entry_t      wdata;
    logic [IW-1:0] raddr;

    // conversion
    logic [15:0] cv_width;
    logic [11:0] cv_ticks;
    logic        cv_on, cv_off;

    sslew_tick_conv u_conv
    (
        .width     (cv_width),
        .off_ticks (cv_ticks),
        .full_on   (cv_on),
        .full_off  (cv_off)
    );

    logic        walk;
    logic        bad_idx;
    logic        last_idx;
    entry_t      upd;
    logic        emit;
    logic        emit_write;
    sslew_pkg::kind_t emit_kind;
    logic [16:0] diff_pos, diff_neg;
    logic [15:0] clamp;
    sslew_pkg::result_t res_next;

    // One result is held back so the final one of a request can carry last
    logic               pend_reg;
    sslew_pkg::result_t pend_res_reg;
    logic               out_fire;
    sslew_pkg::result_t out_res;

    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign busy      = (state_reg != ST_IDLE);
    assign walk      = (cmd_reg.opcode == sslew_pkg::OP_TICK) ||
                       (cmd_reg.opcode == sslew_pkg::OP_DIS_ALL);
    assign bad_idx   = (cmd_reg.servo_index >= 8'(SERVO_COUNT));
    assign last_idx  = (idx_reg == IW'(SERVO_COUNT - 1));
    assign raddr     = idx_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= 1'b1;
            step_reg   <= 16'd10;
            center_reg <= 16'd1500;
            min_reg    <= 16'd1000;
            max_reg    <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sslew_pkg::CFG_SMOOTH: smooth_reg <= cfg_data[0];
                sslew_pkg::CFG_STEP:   step_reg   <= cfg_data;
                sslew_pkg::CFG_CENTER: center_reg <= cfg_data;
                sslew_pkg::CFG_MIN:    min_reg    <= cfg_data;
                sslew_pkg::CFG_MAX:    max_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // State memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[idx_reg] <= wdata;
        rd_reg <= mem[raddr];
    end

    // Modify the entry just read
    always_comb
    begin
        upd        = rd_reg;
        emit       = 1'b0;
        emit_write = 1'b0;
        emit_kind  = sslew_pkg::KIND_ACK;
        cv_width   = 16'd0;
        diff_pos   = {1'b0, rd_reg.tgt} - {1'b0, rd_reg.cur};
        diff_neg   = {1'b0, rd_reg.cur} - {1'b0, rd_reg.tgt};
        clamp      = cmd_reg.pulse_width;
        if (rd_reg.mx < clamp)
            clamp = rd_reg.mx;
        if (rd_reg.mn > clamp)
            clamp = rd_reg.mn;
        case (cmd_reg.opcode)
            sslew_pkg::OP_DIS_ALL:
            begin
                upd.en = 1'b0; upd.mv = 1'b0;
                emit = 1'b1; emit_write = 1'b1;
            end
            sslew_pkg::OP_TICK:
            begin
                if (smooth_reg && rd_reg.en && rd_reg.mv)
                begin
                    emit = 1'b1; emit_write = 1'b1;
                    if (rd_reg.tgt >= rd_reg.cur && diff_pos <= {1'b0, step_reg})
                    begin
                        upd.cur = rd_reg.tgt; upd.mv = 1'b0;
                    end
                    else if (rd_reg.tgt < rd_reg.cur && diff_neg <= {1'b0, step_reg})
                    begin
                        upd.cur = rd_reg.tgt; upd.mv = 1'b0;
                    end
                    else if (rd_reg.tgt > rd_reg.cur)
                        upd.cur = rd_reg.cur + step_reg;
                    else
                        upd.cur = rd_reg.cur - step_reg;
                    cv_width = upd.cur;
                end
            end
            sslew_pkg::OP_SET:
            begin
                emit = 1'b1;
                upd.tgt = clamp; upd.en = 1'b1;
                if (!smooth_reg)
                begin
                    upd.cur = clamp; upd.mv = 1'b0;
                    emit_write = 1'b1; cv_width = clamp;
                end
                else
                    upd.mv = (rd_reg.cur != clamp);
            end
            sslew_pkg::OP_ENABLE:
            begin
                upd.en = 1'b1; emit = 1'b1; emit_write = 1'b1;
                cv_width = rd_reg.cur;
            end
            sslew_pkg::OP_DISABLE:
            begin
                upd.en = 1'b0; upd.mv = 1'b0; emit = 1'b1; emit_write = 1'b1;
            end
            sslew_pkg::OP_CAL:
            begin
                upd.mn = cmd_reg.limit_low; upd.mx = cmd_reg.limit_high;
                upd.cur = cmd_reg.center_width; upd.tgt = cmd_reg.center_width;
                emit = 1'b1;
            end
            sslew_pkg::OP_QUERY:
            begin
                emit = 1'b1; emit_kind = sslew_pkg::KIND_STATUS;
            end
            default: ;
        endcase
    end

    // Sequence the commands and the clearing pass
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        clr_mask_next = clr_mask_reg;
        we            = 1'b0;
        wdata         = upd;
        res_next               = '0;
        res_next.kind          = emit_write ? sslew_pkg::KIND_WRITE : emit_kind;
        res_next.channel       = 4'(idx_reg);
        res_next.full_on       = emit_write && cv_on;
        res_next.full_off      = emit_write && cv_off;
        res_next.off_ticks     = emit_write ? cv_ticks : 12'd0;
        res_next.current_width = upd.cur;
        res_next.target_width  = upd.tgt;
        res_next.is_enabled    = upd.en;
        res_next.is_moving     = upd.mv;
        res_next.ok            = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready &&
                    (cfg_index == sslew_pkg::CFG_CENTER ||
                     cfg_index == sslew_pkg::CFG_MIN ||
                     cfg_index == sslew_pkg::CFG_MAX))
                begin
                    clr_mask_next = {1'b0, cfg_index == sslew_pkg::CFG_CENTER,
                                     cfg_index == sslew_pkg::CFG_MIN,
                                     cfg_index == sslew_pkg::CFG_MAX};
                    idx_next   = '0;
                    state_next = ST_READ;
                end
                else if (start)
                begin
                    if (cmd.opcode == sslew_pkg::OP_NONE ||
                        (cmd.opcode == sslew_pkg::OP_TICK && !smooth_reg))
                        state_next = ST_IDLE;
                    else if (cmd.opcode == sslew_pkg::OP_TICK ||
                             cmd.opcode == sslew_pkg::OP_DIS_ALL)
                    begin
                        idx_next = '0; state_next = ST_READ;
                    end
                    else if (cmd.servo_index >= 8'(SERVO_COUNT))
                        state_next = ST_DONE;
                    else
                    begin
                        idx_next = IW'(cmd.servo_index); state_next = ST_READ;
                    end
                end
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                wdata = rd_reg;
                if (clr_mask_reg[3])
                begin
                    wdata = '0;
                    wdata.cur = center_reg; wdata.tgt = center_reg;
                    wdata.mn = min_reg; wdata.mx = max_reg;
                end
                if (clr_mask_reg[2])
                begin
                    wdata.cur = center_reg; wdata.tgt = center_reg;
                end
                if (clr_mask_reg[1])
                    wdata.mn = min_reg;
                if (clr_mask_reg[0])
                    wdata.mx = max_reg;
                if (last_idx)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next = idx_reg + 1'b1; state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = (clr_mask_reg != 4'd0) ? ST_CLEAR : ST_EXEC;
            ST_EXEC:
            begin
                we = 1'b1;
                if (!walk || last_idx)
                    state_next = ST_DONE;
                else
                begin
                    idx_next = idx_reg + 1'b1; state_next = ST_READ;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Release the held result when a newer one arrives; in the report state
    // release it marked last, or answer a rejected servo index.
    always_comb
    begin
        out_fire = 1'b0;
        out_res  = pend_res_reg;
        case (state_reg)
            ST_EXEC:
                out_fire = emit && pend_reg;
            ST_DONE:
            begin
                if (!walk && bad_idx)
                begin
                    out_res         = '0;
                    out_res.kind    = sslew_pkg::KIND_ACK;
                    out_res.channel = cmd_reg.servo_index[3:0];
                    out_res.last    = 1'b1;
                    out_fire        = 1'b1;
                end
                else
                begin
                    out_res.last = 1'b1;
                    out_fire     = pend_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_READ;
            idx_reg      <= '0;
            clr_mask_reg <= 4'b1000;
            pend_reg     <= 1'b0;
            res_valid    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == ST_CLEAR && last_idx)
                clr_mask_reg <= 4'd0;
            else
                clr_mask_reg <= clr_mask_next;
            res_valid <= out_fire;
            if (state_reg == ST_EXEC && emit)
                pend_reg <= 1'b1;
            else if (state_reg == ST_DONE)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            cmd_reg <= cmd;
        if (state_reg == ST_EXEC && emit)
            pend_res_reg <= res_next;
        if (out_fire)
            res <= out_res;
    end

    // Assertions
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("config accepted while busy");
    a_res_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(state_reg == ST_EXEC || state_reg == ST_DONE))
        else $error("result outside exec");
    a_clear_no_res: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !res_valid)
        else $error("result during clearing pass");

endmodule
